[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the FSK modulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is checked at every edge, reset included.
`define FSK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// Clocked assertion that is ignored while reset is held.
`define FSK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

[hw/rtl/fskecm_pkg.sv]
// Package with the types and constants of the FSK modulator.
package fskecm_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word16_t;

  // Operation carried in the input word's tuser.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_PERIOD_ZERO  = 3'd0;
  localparam logic [2:0] REG_PERIOD_ONE   = 3'd1;
  localparam logic [2:0] REG_EDGES_ZERO   = 3'd2;
  localparam logic [2:0] REG_EDGES_ONE    = 3'd3;
  localparam logic [2:0] REG_PACKET_BYTES = 3'd4;

  typedef struct packed {
    word16_t    period_zero;
    word16_t    period_one;
    word16_t    edges_zero;
    word16_t    edges_one;
    logic [6:0] packet_bytes;
  } cfg_t;

  localparam word16_t MIN_PERIOD = 16'd2;
  localparam word16_t MIN_EDGES  = 16'd1;

endpackage

[hw/rtl/fskecm_store.sv]
// Packet byte store with one write port and one registered read port.
module fskecm_store #(
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  fskecm_pkg::byte_t                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output fskecm_pkg::byte_t                       rdata
);
  import fskecm_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  // A write and a read of the same entry in one cycle return the new byte.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/fsk_edge_counted_modulator_unit.sv]
// Top level of the edge-counted binary FSK square-wave modulator.
//
// Every input word is one operation, given in in_tuser: a clock tick of the
// square-wave generator, a write of one packet byte, or a start command.
// Each accepted word yields exactly one output word on the out_ channel.
// On a tick the output word gives the drive level for that tick, the busy
// flag and the index of the bit being sent; out_tlast marks the tick that
// ends the last bit of the packet. Bits go out MSB first, each as a run of
// falling edges of a 50% duty wave whose period is chosen by the bit value.
// From the input handshake to the earliest output handshake a word passes
// through the input register and then the output register.
// One word is taken in every cycle while the receiver keeps taking output
// words; the packet store's registered read follows the bit position that
// each word leaves behind, so back-to-back ticks see the right byte.
// When the receiver stalls, the output register holds its word, the input
// register fills, and in_tready drops until the output word is taken.
// Synchronous reset empties both registers, stops any transmission and loads
// the configuration defaults; the packet store keeps no reset value.
// Configuration writes on the cfg_ port are always ready and are meant for
// idle periods only.
`include "assert_macros.svh"

module fsk_edge_counted_modulator_unit #(
  parameter int MAX_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] byte_addr, [13:6] byte_value, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Output words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] wave_level, [1] busy_res, [10:2] bit_number,
                                  // [15:11] zero
  output logic        out_tlast,  // packet_done
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fskecm_pkg::*;

  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  // The byte count register holds at most 127, so fewer bytes may be usable.
  localparam int EFF_BYTES = (MAX_BYTES < 127) ? MAX_BYTES : 127;
  localparam int POS_W     = $clog2(EFF_BYTES * 8);
  localparam int TOT_W     = POS_W + 1;

  // Configuration registers.
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_zero  <= 16'd64;
      cfg_r.period_one   <= 16'd48;
      cfg_r.edges_zero   <= 16'd16;
      cfg_r.edges_one    <= 16'd20;
      cfg_r.packet_bytes <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERIOD_ZERO:  cfg_r.period_zero  <= cfg_data;
        REG_PERIOD_ONE:   cfg_r.period_one   <= cfg_data;
        REG_EDGES_ZERO:   cfg_r.edges_zero   <= cfg_data;
        REG_EDGES_ONE:    cfg_r.edges_one    <= cfg_data;
        REG_PACKET_BYTES: cfg_r.packet_bytes <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic       in_valid_r;
  logic [1:0] op_r;
  logic [5:0] addr_r;
  byte_t      val_r;
  logic       adv;

  assign adv       = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[5:0];
      val_r  <= in_tdata[13:6];
    end
  end

  // Transmitter state.
  word16_t          wave_r, wave_nxt;
  word16_t          edge_r, edge_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             send_r, send_nxt;

  // Packet length in bits, with the byte count clamped to the usable range.
  logic [6:0]       nbytes_c;
  logic [TOT_W-1:0] total_c;

  always_comb begin
    nbytes_c = cfg_r.packet_bytes;
    if (nbytes_c == 7'd0) begin
      nbytes_c = 7'd1;
    end else if (32'(nbytes_c) > EFF_BYTES) begin
      nbytes_c = 7'(EFF_BYTES);
    end
    total_c = TOT_W'({nbytes_c, 3'b000});
  end

  // The store always holds in its read register the byte of the current bit.
  logic              wr_ok;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] cur_idx;
  logic [POS_W-1:0]  pos_rd;
  logic [ADDR_W-1:0] raddr;
  byte_t             rd_byte;
  byte_t             byte_c;

  assign wr_ok   = (op_r == OP_WRITE) && (32'(addr_r) < MAX_BYTES);
  assign we      = adv && wr_ok;
  assign waddr   = ADDR_W'(addr_r);
  assign cur_idx = ADDR_W'(pos_r >> 3);
  assign pos_rd  = adv ? pos_nxt : pos_r;
  assign raddr   = ADDR_W'(pos_rd >> 3);

  fskecm_store #(
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (rd_byte)
  );

  // A write to the byte in flight changes the level reported for that word.
  assign byte_c = (wr_ok && (waddr == cur_idx)) ? val_r : rd_byte;

  // Per-bit wave parameters.
  logic    bit_c;
  word16_t per_c;
  word16_t half_c;
  word16_t edges_c;
  logic    level_now;

  always_comb begin
    bit_c   = byte_c[~pos_r[2:0]];
    per_c   = bit_c ? cfg_r.period_one : cfg_r.period_zero;
    edges_c = bit_c ? cfg_r.edges_one : cfg_r.edges_zero;
    if (per_c < MIN_PERIOD) begin
      per_c = MIN_PERIOD;
    end
    if (edges_c < MIN_EDGES) begin
      edges_c = MIN_EDGES;
    end
    half_c    = per_c >> 1;
    level_now = send_r && (wave_r < half_c);
  end

  // Next state and result of the word in the input register.
  logic             level_c;
  logic             busy_c;
  logic             done_c;
  logic             past_end_c;
  logic [POS_W-1:0] bitnum_c;
  logic [16:0]      wave_inc;
  logic [16:0]      edge_inc;

  always_comb begin
    wave_nxt   = wave_r;
    edge_nxt   = edge_r;
    pos_nxt    = pos_r;
    send_nxt   = send_r;
    done_c     = 1'b0;
    past_end_c = ({1'b0, pos_r} >= total_c);
    wave_inc   = 17'(wave_r) + 17'd1;
    edge_inc   = 17'(edge_r) + 17'd1;
    case (op_r)
      OP_TICK: begin
        if (send_r) begin
          if (past_end_c) begin
            send_nxt = 1'b0;
            wave_nxt = '0;
            edge_nxt = '0;
            pos_nxt  = '0;
            done_c   = 1'b1;
          end else begin
            if (wave_inc >= 17'(per_c)) begin
              wave_inc = '0;
            end
            wave_nxt = wave_inc[15:0];
            if (wave_inc == 17'(half_c)) begin
              if (edge_inc >= 17'(edges_c)) begin
                edge_nxt = '0;
                if ((TOT_W'(pos_r) + TOT_W'(1)) >= total_c) begin
                  send_nxt = 1'b0;
                  wave_nxt = '0;
                  pos_nxt  = '0;
                  done_c   = 1'b1;
                end else begin
                  pos_nxt = pos_r + POS_W'(1);
                end
              end else begin
                edge_nxt = edge_inc[15:0];
              end
            end
          end
        end
      end
      OP_START: begin
        if (!send_r) begin
          send_nxt = 1'b1;
          wave_nxt = '0;
          edge_nxt = '0;
          pos_nxt  = '0;
        end
      end
      default: ;
    endcase

    // A tick reports the state it ran in; other words report the state after.
    if (op_r == OP_TICK) begin
      // A tick that finds the bit position already past the packet end only
      // closes the packet, so the line stays low.
      level_c  = level_now && !past_end_c;
      busy_c   = send_r;
      bitnum_c = pos_r;
    end else begin
      // A fresh start always opens in the high half of the wave.
      level_c  = ((op_r == OP_START) && !send_r) ? 1'b1 : level_now;
      busy_c   = send_nxt;
      bitnum_c = pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_r <= 1'b0;
      wave_r <= '0;
      edge_r <= '0;
      pos_r  <= '0;
    end else if (adv) begin
      send_r <= send_nxt;
      wave_r <= wave_nxt;
      edge_r <= edge_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Output register.
  logic        out_tvalid_r;
  logic        out_level_r;
  logic        out_busy_r;
  logic        out_tlast_r;
  logic [8:0]  out_bitnum_r;
  logic [15:0] bitnum_ext;

  assign bitnum_ext = 16'(bitnum_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r  <= level_c;
      out_busy_r   <= busy_c;
      out_tlast_r  <= done_c;
      out_bitnum_r <= bitnum_ext[8:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {5'd0, out_bitnum_r, out_busy_r, out_level_r};

  // While idle the wave, edge and bit counters rest at zero.
  `FSK_ASSERT(a_idle_counters_clear, !send_r |-> (wave_r == '0 && edge_r == '0 && pos_r == '0))
  // A transmission ends only with the word that carries packet_done.
  `FSK_ASSERT(a_end_has_done, $fell(send_r) |-> (out_tvalid_r && out_tlast_r))
  // packet_done is reported on a tick that ran while busy.
  `FSK_ASSERT(a_done_while_busy, (out_tvalid_r && out_tlast_r) |-> out_busy_r)

endmodule

[tb/tb_fsk_edge_counted_modulator_unit.sv]
// Self-checking testbench for the edge-counted FSK modulator top level.
module tb_fsk_edge_counted_modulator_unit;
  import fskecm_pkg::*;

  localparam int STORE_DEPTH = 64;
  // The op code that the package leaves unnamed; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // How packet byte values are chosen within one settings phase.
  localparam int VALUES_RANDOM = 0;
  localparam int VALUES_ONES   = 1;
  localparam int VALUES_ZEROS  = 2;
  localparam int RANDOM_WORDS  = 1550;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] addr;
    logic [7:0] val;
  } mod_word_t;

  typedef struct packed {
    logic       level;
    logic       busy;
    logic       done;
    logic [8:0] bitnum;
  } wave_result_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] data;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [5:0] byte_addr, [13:6] byte_value, [15:14] zero
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [0] wave_level, [1] busy_res, [10:2] bit_number
  logic        out_tlast;       // packet_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  fsk_edge_counted_modulator_unit #(.MAX_BYTES(STORE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the modulator: settings, packet store and transmit state.
  cfg_t        cfg_shadow;
  logic [7:0]  store_shadow [STORE_DEPTH];
  logic [15:0] wave_cnt;
  logic [15:0] edge_cnt;
  logic [8:0]  bit_pos;
  logic        tx_active;

  mod_word_t    stim_q [$];
  wave_result_t result_q [$];
  reg_write_t   reg_q [$];

  mod_word_t   next_word;
  reg_write_t  next_reg;
  int unsigned in_gap;
  int unsigned out_stall;
  logic        quiet_stretch = 1'b0;
  int          value_mode = VALUES_RANDOM;
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned packets_seen = 0;
  int unsigned phases_run = 0;
  int unsigned err_cnt = 0;

  // Gaps and stalls: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned sent_bit_count();
    int unsigned n;
    n = cfg_shadow.packet_bytes;
    if (n < 1) n = 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return n * 8;
  endfunction

  // Bits leave each byte MSB first.
  function automatic logic tx_bit_value();
    logic [7:0] b;
    b = store_shadow[bit_pos[8:3]];
    return b[3'd7 - bit_pos[2:0]];
  endfunction

  function automatic int unsigned active_period();
    int unsigned p;
    p = tx_bit_value() ? cfg_shadow.period_one : cfg_shadow.period_zero;
    return (p < MIN_PERIOD) ? MIN_PERIOD : p;
  endfunction

  function automatic int unsigned active_edges();
    int unsigned e;
    e = tx_bit_value() ? cfg_shadow.edges_one : cfg_shadow.edges_zero;
    return (e < MIN_EDGES) ? MIN_EDGES : e;
  endfunction

  function automatic void stop_transmit();
    tx_active = 1'b0;
    wave_cnt = '0;
    edge_cnt = '0;
    bit_pos = '0;
  endfunction

  // Works out the output word for one accepted input word and advances the
  // shadow state. Ticks report the level before the counter moves.
  task automatic predict_word(input logic [1:0] op, input logic [5:0] addr,
                              input logic [7:0] val);
    wave_result_t r;
    int unsigned  p, h, nxt, ec;
    r = '0;
    if (op == OP_TICK) begin
      r.busy = tx_active;
      r.bitnum = bit_pos;
      if (tx_active) begin
        if (int'(bit_pos) >= sent_bit_count()) begin
          stop_transmit();
          r.done = 1'b1;
        end else begin
          p = active_period();
          h = p >> 1;
          nxt = wave_cnt + 1;
          r.level = (wave_cnt < h);
          if (nxt >= p) nxt = 0;
          // Counter crossing into the low half is a falling edge.
          if (nxt == h) begin
            ec = edge_cnt + 1;
            if (ec >= active_edges()) begin
              edge_cnt = '0;
              if (int'(bit_pos) + 1 >= sent_bit_count()) begin
                stop_transmit();
                r.done = 1'b1;
                nxt = 0;
              end else begin
                bit_pos = bit_pos + 9'd1;
              end
            end else begin
              edge_cnt = ec[15:0];
            end
          end
          if (tx_active) wave_cnt = nxt[15:0];
        end
      end
    end else begin
      if (op == OP_WRITE) begin
        store_shadow[addr] = val;
      end else if (op == OP_START && !tx_active) begin
        tx_active = 1'b1;
        wave_cnt = '0;
        edge_cnt = '0;
        bit_pos = '0;
      end
      if (tx_active) r.level = (wave_cnt < (active_period() >> 1));
      r.busy = tx_active;
      r.bitnum = bit_pos;
    end
    result_q.push_back(r);
  endtask

  // Input driver: one word in flight, a random gap after each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
      stop_transmit();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_word(in_tuser, in_tdata[5:0], in_tdata[13:6]);
        words_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          next_word = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_word.op;
          in_tdata <= {2'b00, next_word.val, next_word.addr};
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Register writes; the shadow settings change when the write is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_shadow = '{period_zero: 16'd64, period_one: 16'd48, edges_zero: 16'd16,
                     edges_one: 16'd20, packet_bytes: 7'd64};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERIOD_ZERO:  cfg_shadow.period_zero = cfg_data;
          REG_PERIOD_ONE:   cfg_shadow.period_one = cfg_data;
          REG_EDGES_ZERO:   cfg_shadow.edges_zero = cfg_data;
          REG_EDGES_ONE:    cfg_shadow.edges_one = cfg_data;
          REG_PACKET_BYTES: cfg_shadow.packet_bytes = cfg_data[6:0];
          default: ;
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_q.size() != 0) begin
          next_reg = reg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_reg.idx;
          cfg_data <= next_reg.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_word();
    wave_result_t want;
    if (result_q.size() == 0) begin
      err_cnt++;
      $display("%0t: output word with none pending, expected nothing, actual %h last %b",
               $time, out_tdata, out_tlast);
      return;
    end
    want = result_q.pop_front();
    compare_field("wave_level", want.level, out_tdata[0]);
    compare_field("busy_res", want.busy, out_tdata[1]);
    compare_field("bit_number", want.bitnum, out_tdata[10:2]);
    compare_field("padding", 0, out_tdata[15:11]);
    compare_field("packet_done", want.done, out_tlast);
    if (out_tlast) packets_seen++;
  endtask

  // Output monitor with its own random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) check_word();
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [5:0] addr,
                           input logic [7:0] val);
    stim_q.push_back('{op: op, addr: addr, val: val});
    words_queued++;
  endtask

  function automatic logic [7:0] pick_value();
    if (value_mode == VALUES_ONES) return 8'hFF;
    if (value_mode == VALUES_ZEROS) return 8'h00;
    return 8'($urandom);
  endfunction

  // Short periods keep packets short; zero and one stand for the minimum.
  function automatic logic [15:0] short_period();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(0, 8));
  endfunction

  function automatic logic [15:0] few_edges();
    return 16'($urandom_range(0, 4));
  endfunction

  function automatic logic [15:0] byte_count();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(4, 8));
    return 16'($urandom_range(0, 3));
  endfunction

  task automatic push_random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82)      push_word(OP_TICK, 6'($urandom), 8'($urandom));
    else if (r < 90) push_word(OP_WRITE, 6'($urandom), pick_value());
    else if (r < 96) push_word(OP_START, 6'($urandom), 8'($urandom));
    else             push_word(OP_UNUSED, 6'($urandom), 8'($urandom));
  endtask

  // Sender holds off until every output word has been checked.
  task automatic wait_for_results();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_tvalid || result_q.size() != 0);
  endtask

  // Ticks the block until the packet in progress has completed, then waits
  // for the two pipeline registers to settle.
  task automatic finish_packet();
    wait_for_results();
    while (tx_active) begin
      repeat (16) push_word(OP_TICK, 6'($urandom), 8'($urandom));
      wait_for_results();
    end
    repeat (4) @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic apply_settings(input logic [15:0] pz, input logic [15:0] po,
                                input logic [15:0] ez, input logic [15:0] eo,
                                input logic [15:0] nb);
    reg_q.push_back('{idx: REG_PERIOD_ZERO, data: pz});
    reg_q.push_back('{idx: REG_PERIOD_ONE, data: po});
    reg_q.push_back('{idx: REG_EDGES_ZERO, data: ez});
    reg_q.push_back('{idx: REG_EDGES_ONE, data: eo});
    reg_q.push_back('{idx: REG_PACKET_BYTES, data: nb});
    do @(negedge clk); while (reg_q.size() != 0 || cfg_valid);
    repeat (2) @(negedge clk);
    phases_run++;
  endtask

  initial begin
    int ph;
    int i;
    int chunk;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // Directed: settings below their minimums, a one-byte packet with both
    // bit values, store address and value extremes, the unused op, an idle
    // tick, a start while busy and a store write during transmission.
    apply_settings(16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
    push_word(OP_WRITE, 6'd63, 8'hFF);
    push_word(OP_WRITE, 6'd1, 8'h00);
    push_word(OP_WRITE, 6'd0, 8'hC3);
    push_word(OP_UNUSED, 6'd0, 8'h00);
    push_word(OP_TICK, 6'd63, 8'hFF);
    push_word(OP_START, 6'd0, 8'h00);
    push_word(OP_START, 6'd63, 8'hFF);
    repeat (5) push_word(OP_TICK, 6'd0, 8'h00);
    push_word(OP_WRITE, 6'd0, 8'h3C);
    push_word(OP_UNUSED, 6'd63, 8'hFF);
    repeat (4) push_word(OP_TICK, 6'd0, 8'h00);
    finish_packet();

    // Random phases. The first fills the whole store, the next two park the
    // largest period and edge values on a bit value that is never sent, and
    // the fourth sends a full-size packet at the fastest rate.
    for (ph = 0; ph < 4 || words_queued < RANDOM_WORDS; ph++) begin
      value_mode = VALUES_RANDOM;
      if (ph == 1) begin
        value_mode = VALUES_ONES;
        apply_settings(16'hFFFF, short_period(), 16'hFFFF, few_edges(),
                       16'($urandom_range(1, 2)));
      end else if (ph == 2) begin
        value_mode = VALUES_ZEROS;
        apply_settings(short_period(), 16'hFFFF, few_edges(), 16'hFFFF,
                       16'($urandom_range(1, 2)));
      end else if (ph == 3) begin
        apply_settings(16'd2, 16'd2, 16'd1, 16'd1, 16'd127);
      end else begin
        apply_settings(short_period(), short_period(), few_edges(), few_edges(),
                       byte_count());
      end
      if (ph == 0) begin
        for (i = 0; i < STORE_DEPTH; i++) push_word(OP_WRITE, 6'(i), 8'($urandom));
      end
      for (i = 0; i < 8; i++) push_word(OP_WRITE, 6'(i), pick_value());
      push_word(OP_START, 6'($urandom), 8'($urandom));
      if (ph != 3) begin
        for (chunk = $urandom_range(2, 5); chunk > 0; chunk--) begin
          quiet_stretch = ($urandom_range(0, 3) == 0);
          repeat ($urandom_range(15, 60)) push_random_word();
          if ($urandom_range(0, 3) == 0) wait_for_results();
        end
      end
      finish_packet();
      quiet_stretch = 1'b0;
    end

    wait_for_results();
    repeat (8) @(negedge clk);
    err_cnt += result_q.size();
    $display("Covered %0d input words over %0d settings phases; %0d packets completed.",
             words_taken, phases_run, packets_seen);
    if (err_cnt == 0) begin
      $display("fsk_edge_counted_modulator_unit test passed");
    end else begin
      $display("fsk_edge_counted_modulator_unit test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("fsk_edge_counted_modulator_unit test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fskecm_pkg.sv
hw/rtl/fskecm_store.sv
hw/rtl/fsk_edge_counted_modulator_unit.sv
tb/tb_fsk_edge_counted_modulator_unit.sv
